FILE: hw/rtl/tid_pkg.sv
// ----------------------------------------------------------------------------
// tid_pkg: shared types and constants for the timed input debouncer
// Poll request layout, configuration register indexes and timing constants.
// ----------------------------------------------------------------------------
package tid_pkg;

    localparam int unsigned TS_W   = 32;   // timestamp width, microseconds
    localparam int unsigned DBC_W  = 10;   // debounce time register width, ms
    localparam int unsigned HOLD_W = 20;   // hold time in us, 1023 * 1000 fits

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = DBC_W;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_LEVEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS  = 1'd1;

    localparam logic [HOLD_W-1:0] US_PER_MS = HOLD_W'(1000);

    // Reset values of the configuration registers
    localparam logic              INVERT_RESET = 1'b1;
    localparam logic [HOLD_W-1:0] HOLD_RESET   = HOLD_W'(20000);   // 20 ms

    // Input stream tdata layout: now_us, then pin_level, zero filled to bytes
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 8;

    typedef struct packed {
        logic [TS_W-1:0] now_us;
        logic            pin_level;
        logic            read_failed;
    } poll_t;

endpackage

FILE: hw/rtl/tid_in_reg.sv
// ----------------------------------------------------------------------------
// tid_in_reg: poll input register
// Captures one poll request per cycle while the qualifier keeps taking them, and holds it for the qualifier.
// ----------------------------------------------------------------------------
module tid_in_reg
    import tid_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // [31:0] now_us, [32] pin_level
    input  logic                 s_tuser,    // [0] read_failed
    input  logic                 take,       // qualifier consumes held poll
    output logic                 poll_valid,
    output poll_t                poll
);

    logic  valid_reg;
    logic  valid_next;
    poll_t poll_reg;

    // free slot, or the held poll leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign valid_next = (s_tvalid && s_tready) ? 1'b1 : (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tvalid && s_tready) begin
            poll_reg.now_us      <= s_tdata[TS_W-1:0];
            poll_reg.pin_level   <= s_tdata[TS_W];
            poll_reg.read_failed <= s_tuser;
        end
    end

    assign poll_valid = valid_reg;
    assign poll       = poll_reg;

endmodule

FILE: hw/rtl/tid_qual.sv
// ----------------------------------------------------------------------------
// tid_qual: level qualifier and result register
// Tracks candidate level and start time, publishes held levels.
// ----------------------------------------------------------------------------
module tid_qual
    import tid_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 poll_valid,
    input  poll_t                poll,
    output logic                 take,
    input  logic                 invert_level,
    input  logic [HOLD_W-1:0]    hold_us,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata     // [0] stable_level
);

    logic            cand_level_reg, cand_level_next;
    logic [TS_W-1:0] cand_start_reg, cand_start_next;
    logic            stable_reg,     stable_next;
    logic            published_reg,  published_next;
    logic            error_reg,      error_next;
    logic            out_valid_reg,  out_valid_next;
    logic            out_level_reg,  out_level_next;

    logic            observed;
    logic [TS_W-1:0] elapsed;
    logic            hold_ok;
    logic            publish;

    assign take     = poll_valid && (!out_valid_reg || m_tready);
    assign observed = poll.pin_level ^ invert_level;
    assign elapsed  = poll.now_us - cand_start_reg;   // wraps mod 2^32
    assign hold_ok  = (hold_us == '0) || (elapsed >= TS_W'(hold_us));

    always_comb begin
        cand_level_next = cand_level_reg;
        cand_start_next = cand_start_reg;
        stable_next     = stable_reg;
        published_next  = published_reg;
        error_next      = error_reg;
        publish         = 1'b0;
        if (take && !error_reg) begin
            if (poll.read_failed) begin
                error_next = 1'b1;
            end else if (observed != cand_level_reg) begin
                // level change restarts the candidate, never publishes
                cand_level_next = observed;
                cand_start_next = poll.now_us;
            end else if (!(published_reg && observed == stable_reg) && hold_ok) begin
                publish        = 1'b1;
                stable_next    = observed;
                published_next = 1'b1;
            end
        end
        out_valid_next = take ? publish : (out_valid_reg && !m_tready);
        out_level_next = publish ? observed : out_level_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_level_reg <= 1'b0;
            cand_start_reg <= '0;
            stable_reg     <= 1'b0;
            published_reg  <= 1'b0;
            error_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            cand_level_reg <= cand_level_next;
            cand_start_reg <= cand_start_next;
            stable_reg     <= stable_next;
            published_reg  <= published_next;
            error_reg      <= error_next;
            out_valid_reg  <= out_valid_next;
        end
        out_level_reg <= out_level_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, out_level_reg};

    // error state is sticky until reset
    a_error_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        error_reg |=> error_reg)
        else $error("error latch cleared without reset");

    // nothing is published once the error is latched
    a_no_publish_in_error: assert property (@(posedge aclk) disable iff (!aresetn)
        !(error_reg && publish))
        else $error("result produced while error latched");

    // a published result always marks the published flag
    a_publish_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        publish |=> (published_reg && m_tvalid && m_tdata[0] == stable_reg))
        else $error("published result out of step with stable level");

endmodule

FILE: hw/rtl/timed_input_debouncer_core.sv
// ----------------------------------------------------------------------------
// timed_input_debouncer_core: timestamp based pin debounce filter
// Qualifies polled pin levels against a configurable hold time.
// ----------------------------------------------------------------------------
// Path: input register, then qualifier result register, then m_.
// Throughput: one poll request per cycle while m_ does not stall; the
//   qualifier updates its state in one pass (32-bit subtract, compare).
// Reset: aresetn synchronous, active low; invert_level = 1, debounce 20 ms,
//   candidate level 0 at time 0, nothing published, error clear.
// ----------------------------------------------------------------------------
module timed_input_debouncer_core
    import tid_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // poll requests
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [31:0] now_us, [32] pin_level
    input  logic                  s_tuser,   // [0] read_failed

    // published levels
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [0] stable_level

    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration. The hold time is kept in microseconds, scaled at write
    // time, so the per-poll path is just the elapsed-time compare.
    logic              invert_reg, invert_next;
    logic [HOLD_W-1:0] hold_reg,   hold_next;

    always_comb begin
        invert_next = invert_reg;
        hold_next   = hold_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_INVERT_LEVEL: invert_next = cfg_wdata[0];
                CFG_DEBOUNCE_MS:  hold_next   = HOLD_W'(cfg_wdata) * US_PER_MS;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            invert_reg <= INVERT_RESET;
            hold_reg   <= HOLD_RESET;
        end else begin
            invert_reg <= invert_next;
            hold_reg   <= hold_next;
        end
    end

    // Input register: frees itself whenever the qualifier takes the poll.
    logic  poll_valid;
    poll_t poll;
    logic  take;

    tid_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .poll_valid (poll_valid),
        .poll       (poll)
    );

    // Qualifier: candidate tracking, error latch and result register.
    tid_qual u_qual (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .poll_valid   (poll_valid),
        .poll         (poll),
        .take         (take),
        .invert_level (invert_reg),
        .hold_us      (hold_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule
